>>> design/swmd_pkg.sv
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared types and constants for the stack with middle-entry delete.
// ----------------------------------------------------------------------------
package swmd_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned COUNT_OUT_W   = 5;

   typedef enum logic [1:0] {
      CMD_NOP    = 2'd0,
      CMD_PUSH   = 2'd1,
      CMD_POP    = 2'd2,
      CMD_DELMID = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                     command;
      logic signed [VALUE_W-1:0]   push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   removed_value;
      logic signed [VALUE_W-1:0]   top_value;
      logic signed [VALUE_W-1:0]   middle_value;
      logic [COUNT_OUT_W-1:0]      entry_count;
      logic                        is_empty;
      logic                        op_error;
   } rsp_type;

endpackage

>>> design/swmd_core.sv
// ----------------------------------------------------------------------------
// swmd_core
// Entry cells, count register and the single-pass command logic. Gives the
// result of the presented command and commits the new state on step.
// ----------------------------------------------------------------------------
module swmd_core import swmd_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type result
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;

   logic                      is_push;
   logic                      is_pop;
   logic                      is_del;
   logic                      empty_now;
   logic                      full_now;
   logic                      error;
   logic [CNT_W-1:0]          last_pos;
   logic [CNT_W-1:0]          mid_pos;
   logic [CNT_W-1:0]          new_last;
   logic [CNT_W-1:0]          new_mid;
   logic signed [VALUE_W-1:0] removed;

   always_comb begin
      is_push   = (req.command == CMD_PUSH);
      is_pop    = (req.command == CMD_POP);
      is_del    = (req.command == CMD_DELMID);
      empty_now = (count_ff == '0);
      full_now  = (count_ff == CNT_W'(DEPTH));
      error     = ((is_pop || is_del) && empty_now) || (is_push && full_now);
      last_pos  = count_ff - CNT_W'(1);
      mid_pos   = last_pos >> 1;

      removed = '0;
      if (!error && is_pop) begin
         removed = entries_ff[last_pos[IDX_W-1:0]];
      end else if (!error && is_del) begin
         removed = entries_ff[mid_pos[IDX_W-1:0]];
      end

      count_in = count_ff;
      if (!error && is_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!error && (is_pop || is_del)) begin
         count_in = last_pos;
      end

      // each cell takes the push value, its upper neighbour, or holds
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (!error && is_push && count_ff == CNT_W'(i)) begin
            entries_in[i] = req.push_value;
         end
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         if (!error && is_del && CNT_W'(i) >= mid_pos) begin
            entries_in[i] = entries_ff[i + 1];
         end
      end

      new_last = count_in - CNT_W'(1);
      new_mid  = new_last >> 1;

      result.removed_value = removed;
      result.top_value     = '0;
      result.middle_value  = '0;
      if (count_in != '0) begin
         result.top_value    = entries_in[new_last[IDX_W-1:0]];
         result.middle_value = entries_in[new_mid[IDX_W-1:0]];
      end
      result.entry_count = COUNT_OUT_W'(count_in);
      result.is_empty    = (count_in == '0);
      result.op_error    = error;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         entries_ff <= entries_in;
      end
   end

endmodule

>>> design/stack_with_middle_delete.sv
// ----------------------------------------------------------------------------
// stack_with_middle_delete
// Bounded stack of signed 32-bit values with push, pop, and read/remove of
// the middle entry (position ceil(n/2) from the bottom).
// ----------------------------------------------------------------------------
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_type (command, push_value)
//   rsp       out        rsp_valid / rsp_ready   rsp_type (removed..op_error)
//
// One beat in, one beat out: the command is applied and its result is
// captured in the output register at the accepting edge.
// A new beat is taken every cycle while the output register is free or
// being drained in the same cycle; otherwise rsp_ready low stalls req_ready.
// Reset clears the entry count and the output valid; entry cells are not
// cleared, as only cells below the count are ever read.
// ----------------------------------------------------------------------------
module stack_with_middle_delete import swmd_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    accept;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   swmd_core #(
      .DEPTH (DEPTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .req    (req_payload),
      .result (result)
   );

   // hold the beat until taken, refill on accept
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stack_with_middle_delete. A behavioural model of
// the stack predicts one result beat per accepted command. A checker compares
// every result beat, field by field, with the oldest prediction. Both sides
// idle at random. Directed tests cover the empty and full corners and the
// delete of the middle entry at odd and even counts. Random bursts follow,
// each biased to grow, shrink or churn the stack.
// ----------------------------------------------------------------------------
module testbench;
   import swmd_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;

   typedef enum int {
      TREND_GROW,
      TREND_SHRINK,
      TREND_MIXED
   } trend_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // model of the stack contents
   logic signed [VALUE_W-1:0] stack_cells [STACK_DEPTH];
   int                        stack_used = 0;

   rsp_type predicted_rsp [$];
   int      fail_count = 0;
   int      next_gap   = 0;
   bit      req_hold   = 1'b0;
   bit      no_idle    = 1'b0;
   int      rsp_wait   = 0;

   stack_with_middle_delete #(
      .DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic rsp_type apply_command(req_type item);
      rsp_type r;
      int      mid;
      int      i;
      r = '0;
      case (item.command)
         CMD_PUSH: begin
            if (stack_used >= STACK_DEPTH) begin
               r.op_error = 1'b1;
            end else begin
               stack_cells[stack_used] = item.push_value;
               stack_used++;
            end
         end
         CMD_POP: begin
            if (stack_used == 0) begin
               r.op_error = 1'b1;
            end else begin
               stack_used--;
               r.removed_value = stack_cells[stack_used];
            end
         end
         CMD_DELMID: begin
            if (stack_used == 0) begin
               r.op_error = 1'b1;
            end else begin
               mid = (stack_used - 1) / 2;
               r.removed_value = stack_cells[mid];
               // close the gap: everything above the middle drops one place
               for (i = mid; i + 1 < stack_used; i++) begin
                  stack_cells[i] = stack_cells[i + 1];
               end
               stack_used--;
            end
         end
         default: ;
      endcase
      if (stack_used > 0) begin
         r.top_value    = stack_cells[stack_used - 1];
         r.middle_value = stack_cells[(stack_used - 1) / 2];
      end
      r.entry_count = COUNT_OUT_W'(stack_used);
      r.is_empty    = (stack_used == 0);
      return r;
   endfunction

   task automatic note_failure(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("[%0t] %s", $time, what);
         $display("   expected rem=%0d top=%0d mid=%0d cnt=%0d empty=%0b err=%0b",
                  want.removed_value, want.top_value, want.middle_value,
                  want.entry_count, want.is_empty, want.op_error);
         $display("   actual   rem=%0d top=%0d mid=%0d cnt=%0d empty=%0b err=%0b",
                  got.removed_value, got.top_value, got.middle_value,
                  got.entry_count, got.is_empty, got.op_error);
      end
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      string   bad;
      if (predicted_rsp.size() == 0) begin
         note_failure("result beat with nothing outstanding", '0, got);
         return;
      end
      want = predicted_rsp.pop_front();
      bad  = "";
      if (got.removed_value !== want.removed_value) bad = {bad, " removed_value"};
      if (got.top_value !== want.top_value)         bad = {bad, " top_value"};
      if (got.middle_value !== want.middle_value)   bad = {bad, " middle_value"};
      if (got.entry_count !== want.entry_count)     bad = {bad, " entry_count"};
      if (got.is_empty !== want.is_empty)           bad = {bad, " is_empty"};
      if (got.op_error !== want.op_error)           bad = {bad, " op_error"};
      if (bad != "") note_failure({"mismatch in", bad}, want, got);
   endtask

   // take result beats; pause at random after each one unless no_idle is set
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_payload);
            rsp_wait = no_idle ? 0 : $urandom_range(0, 9);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   task automatic send_item(cmd_type cmd, logic signed [VALUE_W-1:0] value);
      req_type item;
      item.command    = cmd;
      item.push_value = value;
      repeat (next_gap) @(posedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predicted_rsp.push_back(apply_command(item));
      // hold valid high only when the next beat follows straight away
      next_gap = no_idle ? 0 : $urandom_range(0, 9);
      req_hold = (next_gap == 0);
      if (!req_hold) req_valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      if (req_hold) begin
         req_valid <= 1'b0;
         req_hold = 1'b0;
      end
      @(posedge clock);
      while (predicted_rsp.size() > 0) @(posedge clock);
   endtask

   task automatic test_empty_stack();
      send_item(CMD_NOP, 32'sh1234_5678);
      send_item(CMD_POP, 32'sh0);
      send_item(CMD_DELMID, -32'sh1);
   endtask

   task automatic test_fill_to_full();
      logic signed [VALUE_W-1:0] v;
      int i;
      for (i = 0; i < STACK_DEPTH; i++) begin
         case (i)
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = 32'sh0;
            3: v = -32'sh1;
            4: v = 32'sh5555_5555;
            5: v = 32'shaaaa_aaaa;
            default: v = $urandom;
         endcase
         send_item(CMD_PUSH, v);
      end
      // refused: the stack is full
      send_item(CMD_PUSH, 32'sh0bad_0bad);
   endtask

   task automatic test_delete_middle();
      // even count, then odd, then even again
      send_item(CMD_DELMID, $urandom);
      send_item(CMD_DELMID, $urandom);
      send_item(CMD_DELMID, $urandom);
      send_item(CMD_POP, $urandom);
   endtask

   task automatic test_random_bursts();
      trend_type                 trend;
      logic signed [VALUE_W-1:0] v;
      cmd_type                   cmd;
      int                        burst;
      int                        n;
      int                        r;
      for (burst = 0; burst < 60; burst++) begin
         trend   = trend_type'($urandom_range(0, 2));
         no_idle = ($urandom_range(0, 3) == 0);
         for (n = 0; n < 25; n++) begin
            r = $urandom_range(0, 99);
            case (trend)
               TREND_GROW:
                  cmd = (r < 5) ? CMD_NOP : (r < 70) ? CMD_PUSH :
                        (r < 85) ? CMD_POP : CMD_DELMID;
               TREND_SHRINK:
                  cmd = (r < 5) ? CMD_NOP : (r < 25) ? CMD_PUSH :
                        (r < 62) ? CMD_POP : CMD_DELMID;
               default:
                  cmd = (r < 10) ? CMD_NOP : (r < 55) ? CMD_PUSH :
                        (r < 77) ? CMD_POP : CMD_DELMID;
            endcase
            case ($urandom_range(0, 9))
               0: v = 32'sh8000_0000;
               1: v = 32'sh7fff_ffff;
               2: v = 32'sh0;
               3: v = -32'sh1;
               default: v = $urandom;
            endcase
            send_item(cmd, v);
         end
         // hold off now and then until every result beat is back
         if (burst % 10 == 9) wait_for_drain();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack();
      test_fill_to_full();
      test_delete_middle();
      wait_for_drain();
      test_random_bursts();
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
